@@ src/u8lw_pkg.sv @@
`timescale 1ns / 1ps

package u8lw_pkg;

  // field widths
  localparam int unsigned CP_W    = 21;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned LINE_W  = 12;
  localparam int unsigned WRAP_W  = 10;
  localparam int unsigned LWID_W  = 11;
  localparam int unsigned GRP_MAX = 3;

  // layout constants
  localparam int unsigned LINE_LIMIT   = 4095;
  localparam int unsigned WIDTH_LIMIT  = 1023;
  localparam int unsigned WRAP_RESET   = 200;
  localparam logic [3:0]  NARROW_ADV   = 4'd6;
  localparam logic [3:0]  WIDE_ADV     = 4'd13;
  localparam logic [CP_W-1:0] BAD_CP   = CP_W'(8'h3F);
  localparam logic [CP_W-1:0] NL_CP    = CP_W'(8'h0A);
  localparam logic [CP_W-1:0] WIDE_MIN = CP_W'(8'h80);

  // one decoded code point waiting for placement
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } glyph_t;

  // head of the decoded group as seen by the placement stage
  typedef struct packed {
    logic   valid;
    glyph_t item;
  } grp_head_t;

  // sequence length from a lead byte, 0 for a stray or invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [CP_W-1:0] cp_two(input logic [7:0] a, input logic [7:0] b);
    return {10'd0, a[4:0], b[5:0]};
  endfunction

  function automatic logic [CP_W-1:0] cp_three(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    return {5'd0, a[3:0], b[5:0], c[5:0]};
  endfunction

  function automatic logic [CP_W-1:0] cp_four(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d);
    return {a[2:0], b[5:0], c[5:0], d[5:0]};
  endfunction

endpackage

@@ src/utf8_decode_line_wrap.sv @@
`timescale 1ns / 1ps

// Lenient UTF-8 decoder with greedy line wrap. Text bytes come in one per
// cycle on in_ while in_ready is high; each decoded code point leaves on
// out_ with its pixel column and line index, registered in the group queue
// and then in the placement result register. A byte marked end_of_text
// that releases a cut-short sequence gives up to three code points; the
// input then waits until the last is being placed, as the one placement
// unit places one code point per cycle unless the output stalls. wrap_width
// is written on cfg_we while the block is idle (user's rule, unenforced); resets to 200.
module utf8_decode_line_wrap
  import u8lw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_end_of_text,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CP_W-1:0]     out_code_point,
  output logic [COL_W-1:0]    out_column,
  output logic [LINE_W-1:0]   out_line_index,
  output logic                out_wide_glyph,
  output logic                out_is_newline,
  output logic                out_last_of_text,
  input  logic                cfg_we,
  input  logic [WRAP_W-1:0]   cfg_wdata
);

  logic [WRAP_W-1:0] wrap_width_r;
  grp_head_t         head;
  logic              pop;

  // wrap width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_width_r <= WRAP_W'(WRAP_RESET);
    end else if (cfg_we) begin
      wrap_width_r <= cfg_wdata;
    end
  end

  u8lw_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .pop            (pop),
    .head           (head)
  );

  u8lw_place u_place (
    .clk              (clk),
    .rst_n            (rst_n),
    .wrap_width       (wrap_width_r),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_column       (out_column),
    .out_line_index   (out_line_index),
    .out_wide_glyph   (out_wide_glyph),
    .out_is_newline   (out_is_newline),
    .out_last_of_text (out_last_of_text)
  );

endmodule

@@ src/u8lw_decode.sv @@
`timescale 1ns / 1ps

module u8lw_decode
  import u8lw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  input  logic        pop,
  output grp_head_t   head
);

  logic [7:0]   held_r [GRP_MAX];
  logic [7:0]   held_nxt [GRP_MAX];
  logic [1:0]   held_cnt_r, held_cnt_nxt;
  glyph_t       grp_r [GRP_MAX];
  glyph_t       grp_nxt [GRP_MAX];
  logic [1:0]   grp_cnt_r, grp_cnt_nxt;
  glyph_t       dec_item [GRP_MAX];
  logic [1:0]   dec_cnt;
  logic         accept;

  logic [7:0]   b0, b1, b2;
  logic [2:0]   len0, len1, len2, n_bytes;

  // take a new request once the group drains this cycle
  assign in_ready = (grp_cnt_r == 2'd0) || ((grp_cnt_r == 2'd1) && pop);
  assign accept   = in_valid && in_ready;

  assign head.valid = (grp_cnt_r != 2'd0);
  assign head.item  = grp_r[0];

  // line up held bytes and the new byte
  always_comb begin
    b0 = (held_cnt_r == 2'd0) ? in_text_byte : held_r[0];
    b1 = (held_cnt_r == 2'd1) ? in_text_byte : held_r[1];
    b2 = (held_cnt_r == 2'd2) ? in_text_byte : held_r[2];
    len0 = lead_len(b0);
    len1 = lead_len(b1);
    len2 = lead_len(b2);
    n_bytes = 3'(held_cnt_r) + 3'd1;
  end

  // decode the request into up to three code points
  always_comb begin
    for (int i = 0; i < GRP_MAX; i++) begin
      dec_item[i] = '{cp: BAD_CP, last: 1'b0};
      held_nxt[i] = 8'd0;
    end
    dec_cnt      = 2'd0;
    held_cnt_nxt = 2'd0;
    if (len0 == 3'd0) begin
      dec_cnt = 2'd1;
    end else if (len0 == 3'd1) begin
      dec_item[0].cp = CP_W'(b0);
      dec_cnt        = 2'd1;
    end else if (n_bytes == len0) begin
      case (len0)
        3'd2:    dec_item[0].cp = cp_two(b0, b1);
        3'd3:    dec_item[0].cp = cp_three(b0, b1, b2);
        default: dec_item[0].cp = cp_four(held_r[0], held_r[1], held_r[2], in_text_byte);
      endcase
      dec_cnt = 2'd1;
    end else if (!in_end_of_text) begin
      // keep the unfinished sequence
      held_nxt[0]  = b0;
      held_nxt[1]  = (held_cnt_r >= 2'd1) ? b1 : 8'd0;
      held_nxt[2]  = (held_cnt_r == 2'd2) ? b2 : 8'd0;
      held_cnt_nxt = held_cnt_r + 2'd1;
    end else begin
      // cut short: lead gives '?', the rest is decoded afresh
      dec_cnt = 2'd1;
      if (held_cnt_r != 2'd0) begin
        if (len1 == 3'd1) begin
          dec_item[1].cp = CP_W'(b1);
        end else if ((len1 == 3'd2) && (held_cnt_r == 2'd2)) begin
          dec_item[1].cp = cp_two(b1, b2);
        end
        dec_cnt = 2'd2;
        if ((held_cnt_r == 2'd2) && (len1 != 3'd2)) begin
          if (len2 == 3'd1) begin
            dec_item[2].cp = CP_W'(b2);
          end
          dec_cnt = 2'd3;
        end
      end
    end
    // mark the final code point of the text
    if (in_end_of_text) begin
      case (dec_cnt)
        2'd1:    dec_item[0].last = 1'b1;
        2'd2:    dec_item[1].last = 1'b1;
        2'd3:    dec_item[2].last = 1'b1;
        default: ;
      endcase
    end
  end

  // group queue: load on request, shift on pop
  always_comb begin
    grp_nxt     = grp_r;
    grp_cnt_nxt = grp_cnt_r;
    if (accept) begin
      grp_nxt     = dec_item;
      grp_cnt_nxt = dec_cnt;
    end else if (pop && (grp_cnt_r != 2'd0)) begin
      grp_nxt[0]  = grp_r[1];
      grp_nxt[1]  = grp_r[2];
      grp_cnt_nxt = grp_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      grp_cnt_r  <= 2'd0;
      for (int i = 0; i < GRP_MAX; i++) begin
        held_r[i] <= 8'd0;
      end
    end else begin
      grp_cnt_r <= grp_cnt_nxt;
      if (accept) begin
        held_cnt_r <= held_cnt_nxt;
        held_r     <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  a_end_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_text) |=> (held_cnt_r == 2'd0))
    else $error("held bytes remain after end of text");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_text) |=> (grp_cnt_r != 2'd0))
    else $error("end of text produced no code point");

  a_held_is_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r != 2'd0) |-> (lead_len(held_r[0]) > 3'(held_cnt_r)))
    else $error("held bytes are not an unfinished sequence");

endmodule

@@ src/u8lw_place.sv @@
`timescale 1ns / 1ps

module u8lw_place
  import u8lw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WRAP_W-1:0]   wrap_width,
  input  grp_head_t           head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CP_W-1:0]     out_code_point,
  output logic [COL_W-1:0]    out_column,
  output logic [LINE_W-1:0]   out_line_index,
  output logic                out_wide_glyph,
  output logic                out_is_newline,
  output logic                out_last_of_text
);

  logic [LWID_W-1:0] lw_r, lw_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              out_valid_r;
  logic [CP_W-1:0]   cp_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] oline_r, oline_nxt;
  logic              wide_r, nl_r, last_r;

  logic              out_adv, is_nl, is_wide, brk;
  logic [3:0]        adv;
  logic [11:0]       limit, sum_cur;
  logic [LWID_W-1:0] base_lw;
  logic [11:0]       sum_new;
  logic [LINE_W-1:0] line_inc;

  assign out_adv = !out_valid_r || out_ready;
  assign pop     = head.valid && out_adv;

  // saturating next line index
  always_comb begin
    if ((16'(line_r) < 16'(LINE_LIMIT)) && (line_r != {LINE_W{1'b1}})) begin
      line_inc = line_r + LINE_W'(1);
    end else begin
      line_inc = line_r;
    end
  end

  // greedy placement of the head code point
  always_comb begin
    is_nl   = (head.item.cp == NL_CP);
    is_wide = (head.item.cp >= WIDE_MIN) && !is_nl;
    adv     = is_wide ? WIDE_ADV : NARROW_ADV;
    limit   = (12'(wrap_width) > 12'(WIDTH_LIMIT)) ? 12'(WIDTH_LIMIT) : 12'(wrap_width);
    sum_cur = 12'(lw_r) + 12'(adv);
    brk     = !is_nl && (lw_r != '0) && (sum_cur > limit);
    base_lw = brk ? '0 : lw_r;
    sum_new = 12'(base_lw) + 12'(adv);
    col_nxt   = (base_lw > LWID_W'(1023)) ? COL_W'(1023) : base_lw[COL_W-1:0];
    oline_nxt = brk ? line_inc : line_r;
    if (head.item.last) begin
      lw_nxt   = '0;
      line_nxt = '0;
    end else if (is_nl) begin
      lw_nxt   = '0;
      line_nxt = line_inc;
    end else begin
      lw_nxt   = sum_new[11] ? {LWID_W{1'b1}} : sum_new[LWID_W-1:0];
      line_nxt = oline_nxt;
    end
  end

  // line state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r        <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        lw_r   <= lw_nxt;
        line_r <= line_nxt;
      end
      if (out_adv) begin
        out_valid_r <= head.valid;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pop) begin
      cp_r    <= head.item.cp;
      col_r   <= col_nxt;
      oline_r <= oline_nxt;
      wide_r  <= is_wide;
      nl_r    <= is_nl;
      last_r  <= head.item.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_column       = col_r;
  assign out_line_index   = oline_r;
  assign out_wide_glyph   = wide_r;
  assign out_is_newline   = nl_r;
  assign out_last_of_text = last_r;

  a_newline_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && nl_r) |-> !wide_r)
    else $error("newline flagged as wide glyph");

  a_text_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.item.last) |=> ((lw_r == '0) && (line_r == '0)))
    else $error("line state not cleared after end of text");

endmodule

@@ sim/utf8_decode_line_wrap_tb.sv @@
`timescale 1ns / 1ps

module utf8_decode_line_wrap_tb;
  import u8lw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DIR_ROWS_N     = 26;

  // one placed code point as it leaves the block
  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic              wide;
    logic              nl;
    logic              last;
  } glyph_pos_t;

  // one text byte request, optionally with a hand-written expected glyph
  typedef struct packed {
    logic [7:0] text_byte;
    logic       eot;
    logic       typed;
    glyph_pos_t want;
  } text_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_text_byte = '0;
  logic               in_end_of_text = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CP_W-1:0]    out_code_point;
  logic [COL_W-1:0]   out_column;
  logic [LINE_W-1:0]  out_line_index;
  logic               out_wide_glyph;
  logic               out_is_newline;
  logic               out_last_of_text;
  logic               cfg_we = 1'b0;
  logic [WRAP_W-1:0]  cfg_wdata = '0;

  // decoder and layout state mirrored from the block
  logic [7:0]         part_bytes [3];
  int unsigned        part_cnt = 0;
  int unsigned        pen_x = 0;
  int unsigned        pen_line = 0;
  int unsigned        wrap_px = WRAP_RESET;

  text_row_t          text_q [$];
  glyph_pos_t         glyph_q [$];
  text_row_t          dir_rows [DIR_ROWS_N];
  text_row_t          offer;
  glyph_pos_t         got;
  glyph_pos_t         want;
  int unsigned        q_depth;
  int unsigned        fault_cnt = 0;
  int unsigned        stall_cycles = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  logic               hold_off = 1'b0;

  utf8_decode_line_wrap u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_column       (out_column),
    .out_line_index   (out_line_index),
    .out_wide_glyph   (out_wide_glyph),
    .out_is_newline   (out_is_newline),
    .out_last_of_text (out_last_of_text),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode one accepted byte and queue the glyphs it places
  task automatic decode_and_place(input logic [7:0] b, input logic eot);
    logic [7:0]      seq [4];
    logic [7:0]      c;
    logic [CP_W-1:0] cp;
    int unsigned     n;
    int unsigned     pos;
    int unsigned     len;
    int unsigned     k;
    int unsigned     adv;
    int unsigned     made;
    glyph_pos_t      g;
    n = 0;
    made = 0;
    for (k = 0; k < part_cnt; k++) begin
      seq[n] = part_bytes[k];
      n++;
    end
    seq[n] = b;
    n++;
    part_cnt = 0;
    pos = 0;
    while (pos < n) begin
      c = seq[pos];
      if (!c[7]) len = 1;
      else if (c[7:5] == 3'b110) len = 2;
      else if (c[7:4] == 4'b1110) len = 3;
      else if (c[7:3] == 5'b11110) len = 4;
      else len = 0;
      if (len == 0 || (pos + len > n && eot)) begin
        // stray lead, or a lead cut short by the end of text
        cp = BAD_CP;
        pos++;
      end else if (pos + len > n) begin
        // sequence not complete yet, keep its bytes
        for (k = 0; pos + k < n; k++) part_bytes[k] = seq[pos + k];
        part_cnt = n - pos;
        break;
      end else begin
        case (len)
          1: cp = CP_W'(c);
          2: cp = {10'd0, c[4:0], seq[pos + 1][5:0]};
          3: cp = {5'd0, c[3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]};
          default: cp = {c[2:0], seq[pos + 1][5:0], seq[pos + 2][5:0], seq[pos + 3][5:0]};
        endcase
        pos += len;
      end
      // greedy placement
      g.cp = cp;
      g.nl = (cp == NL_CP);
      g.wide = (cp >= WIDE_MIN);
      g.last = 1'b0;
      adv = g.wide ? WIDE_ADV : NARROW_ADV;
      if (!g.nl && pen_x != 0 && pen_x + adv > wrap_px) begin
        if (pen_line < LINE_LIMIT) pen_line++;
        pen_x = 0;
      end
      g.col = (pen_x > 1023) ? 10'd1023 : COL_W'(pen_x);
      g.line = LINE_W'(pen_line);
      if (g.nl) begin
        if (pen_line < LINE_LIMIT) pen_line++;
        pen_x = 0;
      end else begin
        pen_x = (pen_x + adv > 2047) ? 2047 : pen_x + adv;
      end
      glyph_q.push_back(g);
      made++;
    end
    // end of text flags the final glyph and restarts the layout
    if (eot) begin
      if (made != 0) begin
        g = glyph_q.pop_back();
        g.last = 1'b1;
        glyph_q.push_back(g);
      end
      pen_x = 0;
      pen_line = 0;
      part_cnt = 0;
    end
  endtask

  // request driver, predicts on every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        q_depth = glyph_q.size();
        decode_and_place(offer.text_byte, offer.eot);
        if (offer.typed) begin
          while (glyph_q.size() > q_depth) void'(glyph_q.pop_back());
          glyph_q.push_back(offer.want);
        end
      end
      if (!in_valid || in_ready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = text_q.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= offer.text_byte;
          in_end_of_text <= offer.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // glyph receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_code_point, out_column, out_line_index, out_wide_glyph, out_is_newline,
               out_last_of_text};
        if (glyph_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("%0t: unexpected glyph cp=%h col=%0d line=%0d", $realtime, got.cp,
                     got.col, got.line);
        end else begin
          want = glyph_q.pop_front();
          if (got.cp !== want.cp || got.col !== want.col || got.line !== want.line ||
              got.wide !== want.wide || got.nl !== want.nl || got.last !== want.last) begin
            fault_cnt++;
            if (fault_cnt <= 10) begin
              $display("%0t: glyph mismatch exp cp=%h col=%0d line=%0d w=%b nl=%b last=%b",
                       $realtime, want.cp, want.col, want.line, want.wide, want.nl,
                       want.last);
              $display("  got cp=%h col=%0d line=%0d w=%b nl=%b last=%b",
                       got.cp, got.col, got.line, got.wide, got.nl, got.last);
            end
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_wrap(input logic [WRAP_W-1:0] px);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= px;
    @(posedge clk);
    cfg_we <= 1'b0;
    wrap_px = px;
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || in_valid || glyph_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned len, input logic [7:0] r);
    case (len)
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  // one text of printable ascii, last byte ends it
  task automatic queue_ascii_text(input int unsigned n);
    text_row_t   row;
    int unsigned k;
    for (k = 0; k < n; k++) begin
      row = '0;
      row.text_byte = 8'($urandom_range(8'h20, 8'h7E));
      row.eot = (k == n - 1);
      text_q.push_back(row);
    end
  endtask

  // texts with random content (continuation bytes get random top bits), some noise and cut-short ends
  task automatic queue_random_texts(input int unsigned n_bytes);
    logic [7:0]  txt [$];
    logic [31:0] r;
    text_row_t   row;
    int unsigned added;
    int unsigned glyphs;
    int unsigned g;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    int unsigned conts;
    added = 0;
    while (added < n_bytes) begin
      txt.delete();
      glyphs = $urandom_range(1, 12);
      for (g = 0; g < glyphs; g++) begin
        kind = $urandom_range(99);
        r = $urandom;
        if (kind < 30) begin
          txt.push_back({1'b0, r[6:0]});
        end else if (kind < 40) begin
          txt.push_back(8'h0A);
        end else if (kind < 82) begin
          len = (kind < 58) ? 2 : (kind < 72) ? 3 : 4;
          txt.push_back(lead_byte(len, r[7:0]));
          for (k = 1; k < len; k++) txt.push_back({r[31:30], r[k*6 +: 6]});
        end else if (kind < 92) begin
          txt.push_back(r[8] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]});
        end else begin
          txt.push_back(r[7:0]);
        end
      end
      // text ending inside a sequence
      if ($urandom_range(4) == 0) begin
        r = $urandom;
        len = $urandom_range(2, 4);
        txt.push_back(lead_byte(len, r[7:0]));
        conts = $urandom_range(0, len - 2);
        for (k = 1; k <= conts; k++) txt.push_back({2'b10, r[k*6 +: 6]});
      end
      foreach (txt[i]) begin
        row = '0;
        row.text_byte = txt[i];
        row.eot = (i == txt.size() - 1);
        text_q.push_back(row);
      end
      added += txt.size();
    end
  endtask

  initial begin
    // ascii extremes, stray and invalid leads, sequences of every length, cut-short ends
    dir_rows = '{
      '{8'h41, 1'b0, 1'b1, '{21'h41, 10'd0,  12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{21'h00, 10'd6,  12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h7F, 1'b0, 1'b1, '{21'h7F, 10'd12, 12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h80, 1'b0, 1'b1, '{BAD_CP, 10'd18, 12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hBF, 1'b0, 1'b1, '{BAD_CP, 10'd24, 12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hF8, 1'b0, 1'b1, '{BAD_CP, 10'd30, 12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{BAD_CP, 10'd36, 12'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h0A, 1'b0, 1'b1, '{NL_CP,  10'd42, 12'd0, 1'b0, 1'b1, 1'b0}},
      '{8'hC3, 1'b0, 1'b0, '0},
      '{8'hA9, 1'b0, 1'b0, '0},
      '{8'hE2, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'hAC, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b0, 1'b0, '0},
      '{8'h98, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hF7, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b0, 1'b0, '0},
      '{8'h42, 1'b1, 1'b0, '0},
      '{8'hE2, 1'b1, 1'b1, '{BAD_CP, 10'd0, 12'd0, 1'b0, 1'b0, 1'b1}},
      '{8'h0A, 1'b1, 1'b1, '{NL_CP,  10'd0, 12'd0, 1'b0, 1'b1, 1'b1}}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at the reset wrap width
    foreach (dir_rows[i]) text_q.push_back(dir_rows[i]);
    wait_drained();

    // widest wrap, full rate, receiver held off long enough to back up the input
    set_wrap(10'd1023);
    @(negedge clk);
    queue_ascii_text(24);
    queue_random_texts(16);
    fork
      begin
        repeat (4) @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    wait_drained();

    // zero wrap: every glyph overshoots an empty line and starts its own
    set_wrap(10'd0);
    @(negedge clk);
    queue_ascii_text(12);
    wait_drained();

    // narrow wrap with a slow sender
    set_wrap(WRAP_W'($urandom_range(20, 120)));
    @(negedge clk);
    send_idle_pct = 85;
    queue_random_texts(20);
    wait_drained();

    // minimum wrap with a slow receiver
    set_wrap(10'd1);
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    queue_random_texts(20);
    wait_drained();

    // mid wrap with light idling on both sides
    set_wrap(WRAP_W'($urandom_range(40, 300)));
    @(negedge clk);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_random_texts(20);
    wait_drained();

    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/u8lw_pkg.sv
src/u8lw_decode.sv
src/u8lw_place.sv
src/utf8_decode_line_wrap.sv
sim/utf8_decode_line_wrap_tb.sv
